/* hw/rtl/local_timestep_diagonal_defines.svh */
// Assertion macros for the RTL files; ltd_front uses them.
`ifndef LOCAL_TIMESTEP_DIAGONAL_DEFINES_SVH
`define LOCAL_TIMESTEP_DIAGONAL_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define LTD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define LTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define LTD_ASSERT_IMP(label, clk, rst, ante, cons)
`define LTD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/ltd_pkg.sv */
`default_nettype none

package ltd_pkg;

   localparam int FRAC_BITS    = 32;
   localparam int MATRIX_SLOTS = 65536;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_STAGES   = 63;
   localparam int SQRT_STAGES  = 64;
   localparam int HEAT_W       = 34;
   localparam int CFL_W        = 42;
   localparam int CSR_DATA_W   = 42;

   localparam logic [HEAT_W-1:0] HEAT_RESET = 34'd6012954214;
   localparam logic [CFL_W-1:0]  CFL_RESET  = 42'd4294967296;

   localparam logic signed [63:0] ONE_Q      = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [34:0] HEAT_ONE   = 35'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] SAT_POS    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT_NEG    = 64'sh8000_0000_0000_0000;
   localparam logic [63:0]        BAND_LIMIT = 64'd100000 << FRAC_BITS;

   typedef enum logic [0:0] {
      CSR_HEAT_RATIO = 1'b0,
      CSR_CFL_NUMBER = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        diag_slot;
      logic signed [63:0] density;
      logic signed [63:0] x_momentum;
      logic signed [63:0] y_momentum;
      logic signed [63:0] total_energy;
      logic signed [63:0] length_scale;
      logic signed [63:0] cell_area;
      logic               interior_tag_set;
      logic               boundary_tag_set;
      logic               last_node;
   } req_word_type;

   typedef struct packed {
      logic [15:0]        out_slot;
      logic signed [63:0] diagonal_value;
      logic               timestep_bad;
      logic               area_bad;
      logic               state_invalid;
      logic               end_of_sweep;
   } rsp_word_type;

   // queued word: item plus what the front found out about it
   typedef struct packed {
      req_word_type item;
      logic         far;
      logic         rho_bad;
      logic         abad;
   } fq_word_type;

   // context carried alongside each node through the back pipeline
   typedef struct packed {
      logic [15:0]        slot;
      logic               last;
      logic               far;
      logic               invalid;
      logic               abad;
      logic signed [63:0] rho;
      logic signed [63:0] energy;
      logic signed [63:0] len;
      logic signed [63:0] area;
      logic [127:0]       msq;
      logic [62:0]        vel;
      logic [62:0]        aux;
      logic [63:0]        tmag;
      logic               tneg;
   } ctx_type;

   function automatic logic [63:0] magn(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic out_of_band(input logic [63:0] m);
      return (m == 64'd0) || (m > BAND_LIMIT);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ltd_mac.sv */
`default_nettype none

module ltd_mac (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_valid,
   input  wire logic [63:0]    a,
   input  wire logic [63:0]    b,
   input  wire logic [63:0]    c,
   input  wire logic [63:0]    d,
   input  wire ltd_pkg::ctx_type in_side,
   output logic                out_valid,
   output logic [127:0]        prod,
   output ltd_pkg::ctx_type    out_side
);

   logic             v0_ff, v1_ff, v2_ff;
   logic [63:0]      a_ff, b_ff, c_ff, d_ff;
   logic [63:0]      pp_ff [8];
   logic [63:0]      pp_in [8];
   logic [127:0]     sum_ff, sum_in;
   ltd_pkg::ctx_type s0_ff, s1_ff, s2_ff;

   // 32x32 partial products of a*b and c*d
   always_comb begin
      pp_in[0] = a_ff[31:0]  * b_ff[31:0];
      pp_in[1] = a_ff[31:0]  * b_ff[63:32];
      pp_in[2] = a_ff[63:32] * b_ff[31:0];
      pp_in[3] = a_ff[63:32] * b_ff[63:32];
      pp_in[4] = c_ff[31:0]  * d_ff[31:0];
      pp_in[5] = c_ff[31:0]  * d_ff[63:32];
      pp_in[6] = c_ff[63:32] * d_ff[31:0];
      pp_in[7] = c_ff[63:32] * d_ff[63:32];
      sum_in = 128'(pp_ff[0]) + (128'(pp_ff[1]) << 32) + (128'(pp_ff[2]) << 32)
             + (128'(pp_ff[3]) << 64) + 128'(pp_ff[4]) + (128'(pp_ff[5]) << 32)
             + (128'(pp_ff[6]) << 32) + (128'(pp_ff[7]) << 64);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a;
         b_ff   <= b;
         c_ff   <= c;
         d_ff   <= d;
         pp_ff  <= pp_in;
         sum_ff <= sum_in;
         s0_ff  <= in_side;
         s1_ff  <= s0_ff;
         s2_ff  <= s1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign prod      = sum_ff;
   assign out_side  = s2_ff;

endmodule

`default_nettype wire

/* hw/rtl/ltd_div.sv */
`default_nettype none

module ltd_div (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_valid,
   input  wire logic [127:0]   num,
   input  wire logic [64:0]    den,
   input  wire ltd_pkg::ctx_type in_side,
   output logic                out_valid,
   output logic [62:0]         quot,
   output logic                sat,
   output ltd_pkg::ctx_type    out_side
);

   localparam int STAGES = ltd_pkg::DIV_STAGES;

   logic             valid_ff [STAGES+1];
   logic             valid_in [STAGES+1];
   logic [64:0]      rem_ff   [STAGES+1];
   logic [64:0]      rem_in   [STAGES+1];
   logic [62:0]      lo_ff    [STAGES+1];
   logic [62:0]      lo_in    [STAGES+1];
   logic [62:0]      q_ff     [STAGES+1];
   logic [62:0]      q_in     [STAGES+1];
   logic [64:0]      den_ff   [STAGES+1];
   logic [64:0]      den_in   [STAGES+1];
   logic             sat_ff   [STAGES+1];
   logic             sat_in   [STAGES+1];
   ltd_pkg::ctx_type side_ff  [STAGES+1];
   ltd_pkg::ctx_type side_in  [STAGES+1];

   // one quotient bit per stage; a quotient at or above 2^63 saturates up front
   always_comb begin
      logic [65:0] rs;
      logic        ge;
      valid_in[0] = in_valid;
      rem_in[0]   = num[127:63];
      lo_in[0]    = num[62:0];
      q_in[0]     = '0;
      den_in[0]   = den;
      sat_in[0]   = (num[127:63] >= den);
      side_in[0]  = in_side;
      for (int k = 1; k <= STAGES; k++) begin
         rs          = {rem_ff[k-1], lo_ff[k-1][62]};
         ge          = (rs >= {1'b0, den_ff[k-1]});
         rem_in[k]   = ge ? 65'(rs - {1'b0, den_ff[k-1]}) : rs[64:0];
         q_in[k]     = {q_ff[k-1][61:0], ge};
         lo_in[k]    = {lo_ff[k-1][61:0], 1'b0};
         valid_in[k] = valid_ff[k-1];
         den_in[k]   = den_ff[k-1];
         sat_in[k]   = sat_ff[k-1];
         side_in[k]  = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STAGES; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         lo_ff   <= lo_in;
         q_ff    <= q_in;
         den_ff  <= den_in;
         sat_ff  <= sat_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign quot      = q_ff[STAGES];
   assign sat       = sat_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

`default_nettype wire

/* hw/rtl/ltd_sqrt.sv */
`default_nettype none

module ltd_sqrt (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_valid,
   input  wire logic [127:0]   radicand,
   input  wire ltd_pkg::ctx_type in_side,
   output logic                out_valid,
   output logic [63:0]         root,
   output ltd_pkg::ctx_type    out_side
);

   localparam int STAGES = ltd_pkg::SQRT_STAGES;

   logic             valid_ff [STAGES+1];
   logic             valid_in [STAGES+1];
   logic [127:0]     n_ff     [STAGES+1];
   logic [127:0]     n_in     [STAGES+1];
   logic [65:0]      rem_ff   [STAGES+1];
   logic [65:0]      rem_in   [STAGES+1];
   logic [63:0]      root_ff  [STAGES+1];
   logic [63:0]      root_in  [STAGES+1];
   ltd_pkg::ctx_type side_ff  [STAGES+1];
   ltd_pkg::ctx_type side_in  [STAGES+1];

   // digit-by-digit square root, two radicand bits per stage
   always_comb begin
      logic [67:0] rs;
      logic [67:0] trial;
      logic        ge;
      valid_in[0] = in_valid;
      n_in[0]     = radicand;
      rem_in[0]   = '0;
      root_in[0]  = '0;
      side_in[0]  = in_side;
      for (int k = 1; k <= STAGES; k++) begin
         rs          = {rem_ff[k-1], n_ff[k-1][127:126]};
         trial       = {2'b00, root_ff[k-1], 2'b01};
         ge          = (rs >= trial);
         rem_in[k]   = ge ? 66'(rs - trial) : rs[65:0];
         root_in[k]  = {root_ff[k-1][62:0], ge};
         n_in[k]     = {n_ff[k-1][125:0], 2'b00};
         valid_in[k] = valid_ff[k-1];
         side_in[k]  = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STAGES; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= n_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign root      = root_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

`default_nettype wire

/* hw/rtl/ltd_front.sv */
`default_nettype none

`include "local_timestep_diagonal_defines.svh"

module ltd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ltd_pkg::req_word_type req_data,
   output logic                      full,
   input  wire logic                 take,
   output logic                      head_valid,
   output ltd_pkg::fq_word_type      head
);

   localparam logic [ltd_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
      ltd_pkg::QUEUE_CNT_W'(ltd_pkg::QUEUE_DEPTH);

   ltd_pkg::fq_word_type               mem_ff [ltd_pkg::QUEUE_DEPTH];
   ltd_pkg::fq_word_type               word_in;
   logic [ltd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ltd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ltd_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                               accept;

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign accept     = push && !full;

   // classify the node on the way in
   always_comb begin
      word_in.item    = req_data;
      word_in.far     = !(req_data.interior_tag_set || req_data.boundary_tag_set);
      word_in.rho_bad = (req_data.density <= 64'sd0);
      word_in.abad    = ltd_pkg::out_of_band(ltd_pkg::magn(req_data.cell_area));
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_ff[wr_ptr_ff] <= word_in;
      end
   end

   `LTD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT)
   `LTD_ASSERT_IMP(a_take_nonempty, clock, reset, take, count_ff != '0)
   `LTD_ASSERT_NEXT(a_count_up, clock, reset, accept && !take, count_ff == $past(count_ff) + 1'b1)
   `LTD_ASSERT_NEXT(a_count_down, clock, reset, take && !accept, count_ff == $past(count_ff) - 1'b1)

endmodule

`default_nettype wire

/* hw/rtl/ltd_back.sv */
`default_nettype none

module ltd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [ltd_pkg::HEAT_W-1:0] heat_ratio,
   input  wire logic [ltd_pkg::CFL_W-1:0]  cfl_number,
   input  wire logic                       head_valid,
   input  wire ltd_pkg::fq_word_type       head,
   output logic                            take,
   output logic                            empty,
   input  wire logic                       pop,
   output ltd_pkg::rsp_word_type           rsp_data
);

   logic                  en;
   logic                  v0_ff, out_valid_ff;
   ltd_pkg::fq_word_type  w0_ff;
   ltd_pkg::rsp_word_type out_word_ff, rsp_in;

   logic                  v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11;
   ltd_pkg::ctx_type      c0, c1o, c1, c2, c3o, c3, c4o, c4, c4b, c5o, c5;
   ltd_pkg::ctx_type      c6, c7o, c7, c8o, c8, c9o, c9, c10o, c10, c11;
   logic [127:0]          p1, p5, p6, p9;
   logic [63:0]           r2, r8;
   logic [62:0]           q3, q4, q7, q10, q11;
   logic                  s3, s4, s7, s10, s11;

   logic [63:0]           mx_mag, my_mag;
   logic signed [34:0]    gm1;
   logic [34:0]           gm1_mag;
   logic signed [64:0]    e_w;
   logic signed [63:0]    e_val;
   logic [62:0]           p63, q1, csq;
   logic [64:0]           den_sum;
   logic [62:0]           den63;
   logic [63:0]           t_mag, d_mag;
   logic                  neg11;
   logic signed [63:0]    quot11;

   // whole pipeline freezes while an untaken result sits in the output register
   assign en    = !out_valid_ff || pop;
   assign take  = en && head_valid;
   assign empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v0_ff        <= take;
         out_valid_ff <= v11;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w0_ff       <= head;
         out_word_ff <= rsp_in;
      end
   end

   assign rsp_data = out_word_ff;

   always_comb begin
      c0         = '0;
      c0.slot    = w0_ff.item.diag_slot;
      c0.last    = w0_ff.item.last_node;
      c0.far     = w0_ff.far;
      c0.invalid = w0_ff.rho_bad;
      c0.abad    = w0_ff.abad;
      c0.rho     = w0_ff.item.density;
      c0.energy  = w0_ff.item.total_energy;
      c0.len     = w0_ff.item.length_scale;
      c0.area    = w0_ff.item.cell_area;
      mx_mag     = ltd_pkg::magn(w0_ff.item.x_momentum);
      my_mag     = ltd_pkg::magn(w0_ff.item.y_momentum);
   end

   // |m|^2
   ltd_mac u_mac_msq (
      .clock, .reset, .en, .in_valid(v0_ff),
      .a(mx_mag), .b(mx_mag), .c(my_mag), .d(my_mag), .in_side(c0),
      .out_valid(v1), .prod(p1), .out_side(c1o)
   );

   always_comb begin
      c1     = c1o;
      c1.msq = p1;
   end

   ltd_sqrt u_sqrt_m (
      .clock, .reset, .en, .in_valid(v1), .radicand(c1.msq), .in_side(c1),
      .out_valid(v2), .root(r2), .out_side(c2)
   );

   // |u| = |m|/rho
   ltd_div u_div_vel (
      .clock, .reset, .en, .in_valid(v2),
      .num(128'(r2) << ltd_pkg::FRAC_BITS), .den({1'b0, c2.rho}), .in_side(c2),
      .out_valid(v3), .quot(q3), .sat(s3), .out_side(c3o)
   );

   always_comb begin
      c3     = c3o;
      c3.vel = s3 ? '1 : q3;
   end

   // kinetic energy |m|^2 / (2 rho)
   ltd_div u_div_ke (
      .clock, .reset, .en, .in_valid(v3),
      .num(c3.msq), .den({c3.rho, 1'b0}), .in_side(c3),
      .out_valid(v4), .quot(q4), .sat(s4), .out_side(c4o)
   );

   always_comb begin
      c4     = c4o;
      c4.aux = s4 ? '1 : q4;
      gm1     = $signed({1'b0, heat_ratio}) - ltd_pkg::HEAT_ONE;
      gm1_mag = gm1[34] ? 35'(-gm1) : 35'(gm1);
      e_w     = $signed({c4.energy[63], c4.energy}) - $signed({2'b00, c4.aux});
      e_val   = (e_w[64] != e_w[63]) ? ltd_pkg::SAT_NEG : e_w[63:0];
      c4b      = c4;
      c4b.tneg = gm1[34] ^ e_val[63];
   end

   // p = (gamma-1) * (E - ke)
   ltd_mac u_mac_p (
      .clock, .reset, .en, .in_valid(v4),
      .a(64'(gm1_mag)), .b(ltd_pkg::magn(e_val)), .c('0), .d('0), .in_side(c4b),
      .out_valid(v5), .prod(p5), .out_side(c5o)
   );

   always_comb begin
      c5  = c5o;
      p63 = ((p5 >> (ltd_pkg::FRAC_BITS + 63)) != '0) ? '1 : 63'(p5 >> ltd_pkg::FRAC_BITS);
      // a negative sign with a zero magnitude is still zero pressure
      if (c5o.tneg && ((p5 >> ltd_pkg::FRAC_BITS) != '0)) begin
         c5.invalid = 1'b1;
      end
   end

   // gamma * p
   ltd_mac u_mac_g (
      .clock, .reset, .en, .in_valid(v5),
      .a(64'(heat_ratio)), .b({1'b0, p63}), .c('0), .d('0), .in_side(c5),
      .out_valid(v6), .prod(p6), .out_side(c6)
   );

   assign q1 = ((p6 >> (ltd_pkg::FRAC_BITS + 63)) != '0) ? '1 : 63'(p6 >> ltd_pkg::FRAC_BITS);

   // c^2 = gamma p / rho
   ltd_div u_div_csq (
      .clock, .reset, .en, .in_valid(v6),
      .num(128'(q1) << ltd_pkg::FRAC_BITS), .den({1'b0, c6.rho}), .in_side(c6),
      .out_valid(v7), .quot(q7), .sat(s7), .out_side(c7o)
   );

   always_comb begin
      c7  = c7o;
      csq = s7 ? '1 : q7;
   end

   ltd_sqrt u_sqrt_c (
      .clock, .reset, .en, .in_valid(v7),
      .radicand(128'(csq) << ltd_pkg::FRAC_BITS), .in_side(c7),
      .out_valid(v8), .root(r8), .out_side(c8o)
   );

   always_comb begin
      den_sum = {2'b00, c8o.vel} + {1'b0, r8};
      den63   = (den_sum[64:63] != 2'b00) ? '1 : den_sum[62:0];
      c8      = c8o;
      c8.aux  = den63;
      c8.tneg = c8o.len[63];
      if (den63 == '0) begin
         c8.invalid = 1'b1;
      end
   end

   // CFL * len
   ltd_mac u_mac_t (
      .clock, .reset, .en, .in_valid(v8),
      .a(64'(cfl_number)), .b(ltd_pkg::magn(c8.len)), .c('0), .d('0), .in_side(c8),
      .out_valid(v9), .prod(p9), .out_side(c9o)
   );

   always_comb begin
      if ((p9 >> (ltd_pkg::FRAC_BITS + 63)) != '0) begin
         t_mag = c9o.tneg ? 64'(ltd_pkg::SAT_NEG) : 64'(ltd_pkg::SAT_POS);
      end else begin
         t_mag = {1'b0, 63'(p9 >> ltd_pkg::FRAC_BITS)};
      end
      c9      = c9o;
      c9.tmag = t_mag;
      c9.tneg = c9o.tneg && (t_mag != '0);
   end

   // dt = CFL len / (|u| + c)
   ltd_div u_div_dt (
      .clock, .reset, .en, .in_valid(v9),
      .num(128'(c9.tmag) << ltd_pkg::FRAC_BITS), .den({2'b00, c9.aux}), .in_side(c9),
      .out_valid(v10), .quot(q10), .sat(s10), .out_side(c10o)
   );

   always_comb begin
      if (s10) begin
         d_mag = c10o.tneg ? 64'(ltd_pkg::SAT_NEG) : 64'(ltd_pkg::SAT_POS);
      end else begin
         d_mag = {1'b0, q10};
      end
      c10      = c10o;
      c10.tmag = d_mag;
   end

   // area / dt
   ltd_div u_div_diag (
      .clock, .reset, .en, .in_valid(v10),
      .num(128'(ltd_pkg::magn(c10.area)) << ltd_pkg::FRAC_BITS), .den({1'b0, c10.tmag}),
      .in_side(c10),
      .out_valid(v11), .quot(q11), .sat(s11), .out_side(c11)
   );

   always_comb begin
      neg11 = c11.area[63] ^ c11.tneg;
      if (s11) begin
         quot11 = neg11 ? ltd_pkg::SAT_NEG : ltd_pkg::SAT_POS;
      end else begin
         quot11 = neg11 ? -$signed({1'b0, q11}) : $signed({1'b0, q11});
      end
      rsp_in.out_slot     = 16'(c11.slot % ltd_pkg::MATRIX_SLOTS);
      rsp_in.end_of_sweep = c11.last;
      rsp_in.area_bad     = c11.abad;
      if (c11.far) begin
         rsp_in.diagonal_value = ltd_pkg::ONE_Q;
         rsp_in.timestep_bad   = 1'b0;
         rsp_in.area_bad       = 1'b0;
         rsp_in.state_invalid  = 1'b0;
      end else if (c11.invalid) begin
         rsp_in.diagonal_value = ltd_pkg::SAT_POS;
         rsp_in.timestep_bad   = 1'b1;
         rsp_in.state_invalid  = 1'b1;
      end else begin
         rsp_in.state_invalid = 1'b0;
         rsp_in.timestep_bad  = ltd_pkg::out_of_band(c11.tmag);
         if (c11.tmag == '0) begin
            if (c11.area > 64'sd0) begin
               rsp_in.diagonal_value = ltd_pkg::SAT_POS;
            end else if (c11.area < 64'sd0) begin
               rsp_in.diagonal_value = ltd_pkg::SAT_NEG;
            end else begin
               rsp_in.diagonal_value = '0;
            end
         end else begin
            rsp_in.diagonal_value = quot11;
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/local_timestep_diagonal.sv */
// Local time step and implicit diagonal for 2D Euler mesh nodes. Each word pushed
// in is one node (conserved state, length scale, area, tags, diagonal slot); each
// word popped out is its diagonal value area/dt with dt = CFL*len/(|u|+c), in
// signed Q32.32, saturated, plus bad time step, bad area and invalid state flags.
// Far-field nodes (both tags clear) give exactly 1.0. The block takes one word
// per clock while results are popped and returns results in order. A pushed word
// enters the queue, leaves it into a staging register, then passes four multiply
// units, two 65-stage square root pipelines and five 64-stage divide pipelines,
// one quotient or root bit per stage, and lands in the result register. The whole
// compute pipeline holds while a finished word waits to be popped; a 4-word input
// queue keeps accepting during such a hold until it is full. The user must see
// that registers are written through the csr port only while no node is in
// flight; the block itself does not enforce this. csr_ready is always high.
`default_nettype none

module local_timestep_diagonal (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire ltd_pkg::req_word_type          req_data,
   output logic                                full,
   output logic                                empty,
   input  wire logic                           pop,
   output ltd_pkg::rsp_word_type               rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire ltd_pkg::csr_index_type         csr_index,
   input  wire logic [ltd_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [ltd_pkg::HEAT_W-1:0] heat_ff, heat_in;
   logic [ltd_pkg::CFL_W-1:0]  cfl_ff, cfl_in;
   logic                       take;
   logic                       head_valid;
   ltd_pkg::fq_word_type       head;

   assign csr_ready = 1'b1;

   // decode register writes; keep the value masked to the register width
   always_comb begin
      heat_in = heat_ff;
      cfl_in  = cfl_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ltd_pkg::CSR_HEAT_RATIO: heat_in = csr_data[ltd_pkg::HEAT_W-1:0];
            ltd_pkg::CSR_CFL_NUMBER: cfl_in  = csr_data[ltd_pkg::CFL_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_ff <= ltd_pkg::HEAT_RESET;
         cfl_ff  <= ltd_pkg::CFL_RESET;
      end else begin
         heat_ff <= heat_in;
         cfl_ff  <= cfl_in;
      end
   end

   // front: classify and queue incoming words
   ltd_front u_front (
      .clock, .reset, .push, .req_data, .full,
      .take, .head_valid, .head
   );

   // back: compute pipeline and result register
   ltd_back u_back (
      .clock, .reset, .heat_ratio(heat_ff), .cfl_number(cfl_ff),
      .head_valid, .head, .take, .empty, .pop, .rsp_data
   );

endmodule

`default_nettype wire
